/* sv/ghist_pkg.sv */
// shared types and constants for the gray intensity histogram
// no dependencies; imported by every ghist module except ghist_queue
package ghist_pkg;

    // request kinds
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // default sizing
    localparam int DEF_MAX_BINS   = 256;
    localparam int DEF_COUNT_BITS = 24;

    // luma weights in hundredths and reciprocal of 100 (s * 5243 >> 19 == s / 100, s <= 25500)
    localparam int WEIGHT_R    = 21;
    localparam int WEIGHT_G    = 72;
    localparam int WEIGHT_B    = 7;
    localparam int SUM_BITS    = 15;
    localparam int RECIP       = 5243;
    localparam int RECIP_BITS  = 13;
    localparam int RECIP_SHIFT = 19;

    localparam int GRAY_LEVELS    = 256;
    localparam int OUT_COUNT_BITS = 24;

    // queue sizing (powers of two)
    localparam int WORK_Q_DEPTH = 8;
    localparam int RSP_Q_DEPTH  = 4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] bin_index;
    } request_t;

    typedef struct packed {
        logic [23:0] bin_count;
        logic        count_saturated;
        logic        index_ok;
        logic [8:0]  bins_in_use;
    } result_t;

    // classified request between front and back
    typedef struct packed {
        logic       req_type;
        logic [7:0] idx;
    } work_t;

    // table build / clearing pass control
    typedef struct packed {
        logic       active;
        logic       clear;
        logic [7:0] gray;
        logic [7:0] bin;
    } sweep_t;

endpackage

/* sv/ghist_queue.sv */
// small first-in first-out queue of registers
// generic, no package dependency; DEPTH must be a power of two
module ghist_queue #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH+1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* sv/ghist_cfg.sv */
// bin width register and gray-to-bin table build / clearing pass sequencer
// depends on ghist_pkg
module ghist_cfg #(
    parameter int MAX_BINS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_wdata,
    output ghist_pkg::sweep_t sweep,
    output logic [8:0]        nbins
);

    import ghist_pkg::*;

    logic [8:0] width_reg, width_next;
    logic       active_reg, active_next;
    logic       clear_reg, clear_next;
    logic [7:0] gray_reg, gray_next;
    logic [7:0] bin_reg, bin_next;
    logic [8:0] rem_reg, rem_next;
    logic [8:0] nbins_reg, nbins_next;
    logic [8:0] eff_w_m1;
    logic [8:0] last_bins;

    always_comb
    begin
        // a width of zero acts as one
        eff_w_m1    = (width_reg == 9'd0) ? 9'd0 : width_reg - 9'd1;
        last_bins   = {1'b0, bin_reg} + 9'd1;
        width_next  = width_reg;
        active_next = active_reg;
        clear_next  = clear_reg;
        gray_next   = gray_reg;
        bin_next    = bin_reg;
        rem_next    = rem_reg;
        nbins_next  = nbins_reg;
        if (active_reg)
        begin
            gray_next = gray_reg + 8'd1;
            if (rem_reg == eff_w_m1)
            begin
                rem_next = 9'd0;
                bin_next = bin_reg + 8'd1;
            end
            else
            begin
                rem_next = rem_reg + 9'd1;
            end
            if (gray_reg == 8'(GRAY_LEVELS - 1))
            begin
                active_next = 1'b0;
                clear_next  = 1'b0;
                nbins_next  = (last_bins > 9'(MAX_BINS)) ? 9'(MAX_BINS) : last_bins;
            end
        end
        if (cfg_we)
        begin
            // restart the table build; a pending clear carries on
            width_next  = cfg_wdata;
            active_next = 1'b1;
            gray_next   = 8'd0;
            bin_next    = 8'd0;
            rem_next    = 9'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd1;
            active_reg <= 1'b1;
            clear_reg  <= 1'b1;
            gray_reg   <= 8'd0;
            bin_reg    <= 8'd0;
            rem_reg    <= 9'd0;
            nbins_reg  <= 9'(MAX_BINS);
        end
        else
        begin
            width_reg  <= width_next;
            active_reg <= active_next;
            clear_reg  <= clear_next;
            gray_reg   <= gray_next;
            bin_reg    <= bin_next;
            rem_reg    <= rem_next;
            nbins_reg  <= nbins_next;
        end
    end

    assign sweep.active = active_reg;
    assign sweep.clear  = clear_reg;
    assign sweep.gray   = gray_reg;
    assign sweep.bin    = bin_reg;
    assign nbins        = nbins_reg;

endmodule

/* sv/ghist_front.sv */
// front part: weighted sum, divide by 100, gray-to-bin table lookup, clamp
// depends on ghist_pkg
module ghist_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ghist_pkg::request_t req,
    input  ghist_pkg::sweep_t   sweep,
    input  logic [8:0]          nbins,
    output logic                work_valid,
    output ghist_pkg::work_t    work,
    output logic [1:0]          inflight
);

    import ghist_pkg::*;

    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s1_req_reg, s2_req_reg, s3_req_reg;
    logic [7:0]           s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [SUM_BITS-1:0]  s1_sum_reg, s1_sum_next;
    logic [7:0]           s2_gray_reg, s2_gray_next;
    logic [7:0]           s3_bin_reg;
    logic [PROD_BITS-1:0] prod;
    logic [7:0]           tbl [GRAY_LEVELS];
    logic [7:0]           last_bin;

    always_comb
    begin
        s1_sum_next = SUM_BITS'(WEIGHT_R) * SUM_BITS'(req.red)
                    + SUM_BITS'(WEIGHT_G) * SUM_BITS'(req.green)
                    + SUM_BITS'(WEIGHT_B) * SUM_BITS'(req.blue);
        prod         = PROD_BITS'(s1_sum_reg) * PROD_BITS'(RECIP);
        s2_gray_next = prod[RECIP_SHIFT +: 8];
        last_bin     = 8'(nbins - 9'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg  <= req.req_type;
        s1_idx_reg  <= req.bin_index;
        s1_sum_reg  <= s1_sum_next;
        s2_req_reg  <= s1_req_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_gray_reg <= s2_gray_next;
        s3_req_reg  <= s2_req_reg;
        s3_idx_reg  <= s2_idx_reg;
    end

    // gray level to raw bin, filled by the table build pass
    always_ff @(posedge clk)
    begin
        if (sweep.active)
        begin
            tbl[sweep.gray] <= sweep.bin;
        end
        s3_bin_reg <= tbl[s2_gray_reg];
    end

    always_comb
    begin
        work_valid    = s3_valid_reg;
        work.req_type = s3_req_reg;
        if (s3_req_reg == REQ_READ)
        begin
            work.idx = s3_idx_reg;
        end
        else if ({1'b0, s3_bin_reg} >= nbins)
        begin
            // bins beyond the cap fold into the last bin
            work.idx = last_bin;
        end
        else
        begin
            work.idx = s3_bin_reg;
        end
        inflight = 2'(s1_valid_reg) + 2'(s2_valid_reg) + 2'(s3_valid_reg);
    end

endmodule

/* sv/ghist_back.sv */
// back part: count memory with read-modify-write, read-and-clear, result build
// depends on ghist_pkg
module ghist_back #(
    parameter int MAX_BINS   = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               work_pop,
    input  ghist_pkg::work_t   work,
    input  ghist_pkg::sweep_t  sweep,
    input  logic [8:0]         nbins,
    output logic               rsp_valid,
    output ghist_pkg::result_t rsp,
    output logic               read_pending
);

    import ghist_pkg::*;

    localparam int BIN_BITS = $clog2(MAX_BINS);
    localparam int WIDE_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WIDE_BITS-1:0]  OUT_MAX   = WIDE_BITS'({OUT_COUNT_BITS{1'b1}});

    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  b_valid_reg;
    logic                  b_req_reg;
    logic                  b_ok_reg;
    logic [BIN_BITS-1:0]   b_addr_reg;
    logic                  fwd_valid_reg, fwd_valid_next;
    logic [BIN_BITS-1:0]   fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] cur;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;
    logic [WIDE_BITS-1:0]  cnt_wide;
    logic                  is_max;

    always_comb
    begin
        // newest write was not yet visible to this entry's read
        cur = (fwd_valid_reg && fwd_addr_reg == b_addr_reg) ? fwd_data_reg : rd_data_reg;
        is_max = (cur == COUNT_MAX);
        if (b_req_reg == REQ_READ)
        begin
            wr_en   = b_valid_reg && b_ok_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = b_valid_reg;
            wr_data = is_max ? cur : cur + COUNT_BITS'(1);
        end
        fwd_valid_next = wr_en;
        cnt_wide = b_ok_reg ? WIDE_BITS'(cur) : '0;

        rsp_valid           = b_valid_reg && (b_req_reg == REQ_READ);
        rsp.bin_count       = (cnt_wide > OUT_MAX) ? OUT_COUNT_BITS'(OUT_MAX)
                                                   : OUT_COUNT_BITS'(cnt_wide);
        rsp.count_saturated = b_ok_reg && is_max;
        rsp.index_ok        = b_ok_reg;
        rsp.bins_in_use     = nbins;
        read_pending        = rsp_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= work_pop;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            b_req_reg  <= work.req_type;
            b_ok_reg   <= ({1'b0, work.idx} < nbins);
            b_addr_reg <= work.idx[BIN_BITS-1:0];
        end
        fwd_addr_reg <= b_addr_reg;
        fwd_data_reg <= wr_data;
    end

    // count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sweep.active && sweep.clear)
        begin
            mem[sweep.gray[BIN_BITS-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[b_addr_reg] <= wr_data;
        end
        if (work_pop)
        begin
            rd_data_reg <= mem[work.idx[BIN_BITS-1:0]];
        end
    end

endmodule

/* sv/gray_intensity_histogram_unit.sv */
// gray intensity histogram: rgb pixel to luma bin count, read-and-clear of one bin
// read path: front stages s1 to s3, work queue, back read register, result queue onto rsp
// throughput: one request per cycle unless full; the one-read one-write count memory forwards
// reset: a pass clears the counts and builds the gray-to-bin table, full held high
// a width write restarts the table build (counts kept unless still clearing), full held high
module gray_intensity_histogram_unit #(
    parameter int MAX_BINS   = ghist_pkg::DEF_MAX_BINS,
    parameter int COUNT_BITS = ghist_pkg::DEF_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    // request side
    input  logic                push,
    output logic                full,
    input  ghist_pkg::request_t req,
    // result side
    output logic                empty,
    input  logic                pop,
    output ghist_pkg::result_t  rsp,
    // bin width register
    input  logic                cfg_we,
    input  logic [8:0]          cfg_wdata
);

    import ghist_pkg::*;

    localparam int WQ_CNT_BITS = $clog2(WORK_Q_DEPTH + 1);
    localparam int RQ_CNT_BITS = $clog2(RSP_Q_DEPTH + 1);
    localparam int CREDIT_BITS = WQ_CNT_BITS + 1;

    sweep_t                 sweep;
    logic [8:0]             nbins;
    logic                   accept;
    logic                   work_valid;
    work_t                  work_in;
    work_t                  work_head;
    logic [1:0]             inflight;
    logic [WQ_CNT_BITS-1:0] work_count;
    logic                   work_pop;
    logic                   rsp_push;
    result_t                rsp_new;
    logic                   read_pending;
    logic [RQ_CNT_BITS-1:0] rsp_count;
    logic [CREDIT_BITS-1:0] credit_used;

    // width register and the table build / clearing pass
    ghist_cfg #(
        .MAX_BINS (MAX_BINS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sweep     (sweep),
        .nbins     (nbins)
    );

    // requests in flight in the front count against the work queue so it never overflows
    assign credit_used = CREDIT_BITS'(inflight) + CREDIT_BITS'(work_count);
    assign full        = sweep.active || (credit_used >= CREDIT_BITS'(WORK_Q_DEPTH));
    assign accept      = push && !full;

    // front: luma, bin lookup and clamp
    ghist_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (req),
        .sweep      (sweep),
        .nbins      (nbins),
        .work_valid (work_valid),
        .work       (work_in),
        .inflight   (inflight)
    );

    // classified requests waiting for the counts memory
    ghist_queue #(
        .WIDTH ($bits(work_t)),
        .DEPTH (WORK_Q_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_valid),
        .wdata (work_in),
        .pop   (work_pop),
        .rdata (work_head),
        .count (work_count)
    );

    // the back takes a request only when a result it may produce has room
    assign work_pop = (work_count != '0)
                   && ((RQ_CNT_BITS'(rsp_count) + RQ_CNT_BITS'(read_pending))
                       < RQ_CNT_BITS'(RSP_Q_DEPTH));

    // back: counts memory update and read-and-clear
    ghist_back #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_pop     (work_pop),
        .work         (work_head),
        .sweep        (sweep),
        .nbins        (nbins),
        .rsp_valid    (rsp_push),
        .rsp          (rsp_new),
        .read_pending (read_pending)
    );

    // result queue parts the back from the consumer
    ghist_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RSP_Q_DEPTH)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rsp_push),
        .wdata (rsp_new),
        .pop   (pop && !empty),
        .rdata (rsp),
        .count (rsp_count)
    );

    assign empty = (rsp_count == '0);

    // work queue plus front never exceed the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= CREDIT_BITS'(WORK_Q_DEPTH))
        else $error("work queue credit exceeded");

    // result queue always has room when the back delivers
    a_rsp_room: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |-> (rsp_count < RQ_CNT_BITS'(RSP_Q_DEPTH)) || (pop && !empty))
        else $error("result queue overflow");

    // clearing pass runs with nothing in flight
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sweep.active && sweep.clear) |-> (inflight == 2'd0) && (work_count == '0)
                                          && !work_pop)
        else $error("request in flight during clearing pass");

    // bin count in use is valid once the table is built
    a_nbins_range: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sweep.active) |-> (nbins != 9'd0) && (nbins <= 9'(MAX_BINS)))
        else $error("bins in use out of range");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking testbench for gray_intensity_histogram_unit
// depends on ghist_pkg and the unit; keeps its own histogram predictor
module tb_top;
    import ghist_pkg::*;

    // timing and run shape
    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 12;    // room after the last read result for accumulates still in flight
    localparam int STALL_LIMIT     = 4000;  // covers the table build passes and hold-off
    localparam int PHASE_ITEMS     = 48;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int HOLD_OFF_CYCLES = 150;

    // histogram model sizing and luma weights in hundredths
    localparam int          BIN_SLOTS  = 256;
    localparam int          GRAY_SPAN  = 256;
    localparam logic [23:0] COUNT_TOP  = 24'hFFFFFF;
    localparam int          LUMA_R     = 21;
    localparam int          LUMA_G     = 72;
    localparam int          LUMA_B     = 7;
    localparam int          LUMA_DIV   = 100;

    typedef enum logic {ROW_REQ, ROW_WIDTH} row_kind_e;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    // one line of the directed plan: a request or a bin width change
    typedef struct {
        row_kind_e  kind;
        logic [8:0] width;
        request_t   rq;
        bit         typed;
        result_t    want;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    request_t   req;
    logic       empty;
    logic       pop;
    result_t    rsp;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    // predictor state: bin counts and the bin width register
    logic [23:0] hist_model [BIN_SLOTS];
    logic [8:0]  width_model;
    result_t     want_q [$];        // read results still owed by the unit
    plan_row_t   plan [$];
    request_t    last_pixel;
    int          last_bin;

    // knobs set by the main sequence, the last two read by the receiver process
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;

    // bookkeeping
    int errors      = 0;
    int quiet_count = 0;
    int n_accum     = 0;
    int n_reads     = 0;
    int n_bad_index = 0;
    int n_checked   = 0;
    int n_widths    = 0;

    logic [8:0] phase_widths [10] = '{9'd1, 9'd2, 9'd256, 9'd0, 9'd511,
                                      9'd7, 9'd100, 9'd129, 9'd255, 9'd3};

    gray_intensity_histogram_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // a zero width divides like a width of one
    function automatic int live_width(logic [8:0] w);
        return (w == 9'd0) ? 1 : int'(w);
    endfunction

    // ceil(256 / width), never above the number of bin slots
    function automatic int live_bins(logic [8:0] w);
        int d;
        int n;
        d = live_width(w);
        n = (GRAY_SPAN + d - 1) / d;
        if (n > BIN_SLOTS)
            n = BIN_SLOTS;
        return n;
    endfunction

    // truncated luma, divided down to a bin, folded into the last bin in use
    function automatic int pixel_bin(request_t r, logic [8:0] w);
        int gray;
        int b;
        gray = (LUMA_R * int'(r.red) + LUMA_G * int'(r.green) + LUMA_B * int'(r.blue))
               / LUMA_DIV;
        b = gray / live_width(w);
        if (b >= live_bins(w))
            b = live_bins(w) - 1;
        return b;
    endfunction

    // advance the histogram model by one request; reads give a result
    task automatic apply_request(input request_t r, output bit made, output result_t res);
        int n;
        int b;
        n    = live_bins(width_model);
        res  = '0;
        made = 1'b0;
        if (r.req_type == REQ_ACCUM)
        begin
            b = pixel_bin(r, width_model);
            last_bin = b;
            if (hist_model[b] != COUNT_TOP)
                hist_model[b] = hist_model[b] + 24'd1;
            n_accum++;
        end
        else
        begin
            made = 1'b1;
            n_reads++;
            res.bins_in_use = n[8:0];
            if (int'(r.bin_index) < n)
            begin
                res.index_ok        = 1'b1;
                res.bin_count       = hist_model[r.bin_index];
                res.count_saturated = (hist_model[r.bin_index] == COUNT_TOP);
                hist_model[r.bin_index] = '0;
            end
            else
            begin
                // out of range index: zero count, nothing cleared
                n_bad_index++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // offer one request from a falling edge until it is taken; ends on a falling edge
    task automatic send_request(input request_t r, input bit typed, input result_t want);
        bit      made;
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        req  = r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_request(r, made, res);
        // typed rows keep their hand-written answer, the rest follow the predictor
        if (made)
            want_q.insert(want_q.size(), typed ? want : res);
        @(negedge clk);
    endtask

    // change the bin width only once the unit has gone quiet
    task automatic write_width(input logic [8:0] w);
        push = 1'b0;
        while (want_q.size() != 0)
            @(negedge clk);
        // accumulates leave no result behind, so let the pipeline empty out
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = w;
        @(negedge clk);
        cfg_we      = 1'b0;
        width_model = w;
        n_widths++;
    endtask

    // directed plan builders
    task automatic add_width(input logic [8:0] w);
        plan_row_t row;
        row       = '{kind: ROW_WIDTH, default: '0};
        row.kind  = ROW_WIDTH;
        row.width = w;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        plan_row_t row;
        row                 = '{kind: ROW_REQ, default: '0};
        row.kind            = ROW_REQ;
        row.rq.req_type     = REQ_ACCUM;
        row.rq.red          = r;
        row.rq.green        = g;
        row.rq.blue         = b;
        row.rq.bin_index    = 8'($urandom_range(255));   // ignored by an accumulate
        plan.insert(plan.size(), row);
    endtask

    task automatic add_read(input logic [7:0] idx, input bit typed, input logic [23:0] cnt,
                            input logic ok, input logic [8:0] n);
        plan_row_t row;
        row                      = '{kind: ROW_REQ, default: '0};
        row.kind                 = ROW_REQ;
        row.rq.req_type          = REQ_READ;
        row.rq.red               = 8'($urandom_range(255));   // pixel fields ignored on reads
        row.rq.green             = 8'($urandom_range(255));
        row.rq.blue              = 8'($urandom_range(255));
        row.rq.bin_index         = idx;
        row.typed                = typed;
        row.want.bin_count       = cnt;
        row.want.count_saturated = 1'b0;
        row.want.index_ok        = ok;
        row.want.bins_in_use     = n;
        plan.insert(plan.size(), row);
    endtask

    // random request: mostly pixels, often repeating a color so bins build up,
    // reads aimed at the last touched bin, at random live bins, or anywhere
    function automatic request_t random_request();
        request_t r;
        int       pick;
        r.req_type  = ($urandom_range(99) < 35) ? REQ_READ : REQ_ACCUM;
        r.red       = 8'($urandom_range(255));
        r.green     = 8'($urandom_range(255));
        r.blue      = 8'($urandom_range(255));
        r.bin_index = 8'($urandom_range(255));
        if (r.req_type == REQ_ACCUM)
        begin
            if ($urandom_range(99) < 40)
            begin
                r.red   = last_pixel.red;
                r.green = last_pixel.green;
                r.blue  = last_pixel.blue;
            end
            last_pixel = r;
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                r.bin_index = 8'(last_bin);
            else if (pick < 85)
                r.bin_index = 8'($urandom_range(live_bins(width_model) - 1));
        end
        return r;
    endfunction

    // receiver: random pop, or a long counted hold-off when asked
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                pop = 1'b0;
                hold_req--;
            end
            else
                pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check against the oldest owed read result
    always @(posedge clk)
    begin : check_rsp
        result_t exp_rsp;
        if (rst_n && pop && !empty)
        begin
            if (want_q.size() == 0)
                report_mismatch("result with nothing owed, bin_count", int'(rsp.bin_count), 0);
            else
            begin
                exp_rsp = want_q.pop_front();
                n_checked++;
                if (rsp.bin_count !== exp_rsp.bin_count)
                    report_mismatch("bin_count", int'(rsp.bin_count), int'(exp_rsp.bin_count));
                if (rsp.count_saturated !== exp_rsp.count_saturated)
                    report_mismatch("count_saturated", int'(rsp.count_saturated),
                                    int'(exp_rsp.count_saturated));
                if (rsp.index_ok !== exp_rsp.index_ok)
                    report_mismatch("index_ok", int'(rsp.index_ok), int'(exp_rsp.index_ok));
                if (rsp.bins_in_use !== exp_rsp.bins_in_use)
                    report_mismatch("bins_in_use", int'(rsp.bins_in_use),
                                    int'(exp_rsp.bins_in_use));
            end
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("FAIL gray_intensity_histogram_unit");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        push           = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = 9'd1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        width_model    = 9'd1;
        last_bin       = 0;
        last_pixel     = '0;
        for (int i = 0; i < BIN_SLOTS; i++)
            hist_model[i] = '0;

        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed plan, width 1 after reset: all 256 bins, counts cleared
        add_read(8'd0, 1'b1, 24'd0, 1'b1, 9'd256);
        add_read(8'd255, 1'b1, 24'd0, 1'b1, 9'd256);
        add_pixel(8'd0, 8'd0, 8'd0);             // black lands in bin 0
        add_pixel(8'd255, 8'd255, 8'd255);       // white lands in bin 255
        add_read(8'd0, 1'b1, 24'd1, 1'b1, 9'd256);
        add_read(8'd255, 1'b1, 24'd1, 1'b1, 9'd256);
        add_read(8'd0, 1'b1, 24'd0, 1'b1, 9'd256);     // read clears the bin
        add_pixel(8'd255, 8'd0, 8'd0);           // each primary alone
        add_pixel(8'd0, 8'd255, 8'd0);
        add_pixel(8'd0, 8'd0, 8'd255);
        add_pixel(8'd255, 8'd0, 8'd0);
        add_read(8'd53, 1'b0, '0, 1'b0, '0);
        add_read(8'd183, 1'b0, '0, 1'b0, '0);
        add_read(8'd17, 1'b0, '0, 1'b0, '0);
        // zero width behaves as width one
        add_width(9'd0);
        add_pixel(8'd1, 8'd1, 8'd1);
        add_read(8'd1, 1'b1, 24'd1, 1'b1, 9'd256);
        // width 256: a single bin, anything above it is out of range
        add_width(9'd256);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_read(8'd0, 1'b1, 24'd1, 1'b1, 9'd1);
        add_read(8'd1, 1'b1, 24'd0, 1'b0, 9'd1);
        // width past 256 still gives one bin
        add_width(9'd511);
        add_pixel(8'd200, 8'd100, 8'd50);
        add_read(8'd0, 1'b1, 24'd1, 1'b1, 9'd1);
        add_read(8'd255, 1'b1, 24'd0, 1'b0, 9'd1);
        // uneven width: 86 bins, white in the last one
        add_width(9'd3);
        add_pixel(8'd255, 8'd255, 8'd255);
        add_read(8'd85, 1'b0, '0, 1'b0, '0);
        add_read(8'd86, 1'b1, 24'd0, 1'b0, 9'd86);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WIDTH)
                write_width(plan[i].width);
            else
                send_request(plan[i].rq, plan[i].typed, plan[i].want);
        end

        // random phases, each at its own width and idling mode
        foreach (phase_widths[p])
        begin
            case (idle_mode_e'(p % 4))
                IDLE_NONE:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                IDLE_SEND:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                IDLE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            write_width(phase_widths[p]);
            repeat (PHASE_ITEMS)
                send_request(random_request(), 1'b0, '0);
        end

        // back-pressure: results held off while requests keep coming, so full must rise
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_width(9'd5);
        hold_req = HOLD_OFF_CYCLES;
        repeat (PRESSURE_ITEMS)
        begin : pressure_item
            request_t r;
            r = random_request();
            if ($urandom_range(1) == 1)
                r.req_type = REQ_READ;
            send_request(r, 1'b0, '0);
        end

        // drain, then leave time for anything stray to surface
        push = 1'b0;
        while (want_q.size() != 0)
            @(negedge clk);
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d pixels and %0d bin reads (%0d out of range) over %0d width writes",
                 n_accum, n_reads, n_bad_index, n_widths);
        $display("%0d results compared, %0d mismatches", n_checked, errors);
        if (errors == 0)
            $display("PASS gray_intensity_histogram_unit");
        else
            $display("FAIL gray_intensity_histogram_unit");
        $finish;
    end

endmodule

/* sim.f */
sv/ghist_pkg.sv
sv/ghist_queue.sv
sv/ghist_cfg.sv
sv/ghist_front.sv
sv/ghist_back.sv
sv/gray_intensity_histogram_unit.sv
tb/tb_top.sv
